// ----- rtl/fsop_pkg.sv -----
// shared types, character codes and helpers for the format specifier option parser
package fsop_pkg;

  typedef enum logic [3:0] {
    PH_STAR1   = 4'd0,
    PH_FLAGS1  = 4'd1,
    PH_WSTART  = 4'd2,
    PH_WDIGITS = 4'd3,
    PH_PSTART  = 4'd4,
    PH_PDIGITS = 4'd5,
    PH_LEN     = 4'd6,
    PH_FLAGS2  = 4'd7,
    PH_STAR2   = 4'd8,
    PH_STOP    = 4'd9
  } phase_t;

  localparam int NUM_PHASES = 10;

  // character codes
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SHARP  = 8'h23;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_LOW_H  = 8'h68;
  localparam logic [7:0] CH_LOW_L  = 8'h6C;
  localparam logic [7:0] CH_UP_L   = 8'h4C;
  localparam logic [7:0] CH_LOW_J  = 8'h6A;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;

  // flag bit positions
  localparam int FL_SHARP = 0;
  localparam int FL_ZERO  = 1;
  localparam int FL_PLUS  = 2;
  localparam int FL_MINUS = 3;
  localparam int FL_SPACE = 4;

  // modifier levels
  localparam logic [1:0] LVL_NONE   = 2'd0;
  localparam logic [1:0] LVL_SINGLE = 2'd1;
  localparam logic [1:0] LVL_DOUBLE = 2'd2;

  // result field widths
  localparam int CH_W      = 8;
  localparam int FLAGS_W   = 5;
  localparam int FIELD_W   = 16;
  localparam int LVL_W     = 2;
  localparam int OUT_BITS  = CH_W + FLAGS_W + 2 * FIELD_W + 1 + 2 * LVL_W + 4;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    phase_t             phase;
    logic [FLAGS_W-1:0] flags;
    logic               prec_seen;
    logic [LVL_W-1:0]   short_lvl;
    logic [LVL_W-1:0]   long_lvl;
    logic               intmax;
    logic               sizet;
    logic               pend_h;
    logic               pend_l;
    logic               star_first;
    logic               star_last;
  } ctl_t;

  localparam ctl_t CTL_RESET = '{
    phase:      PH_STAR1,
    flags:      '0,
    prec_seen:  1'b0,
    short_lvl:  LVL_NONE,
    long_lvl:   LVL_NONE,
    intmax:     1'b0,
    sizet:      1'b0,
    pend_h:     1'b0,
    pend_l:     1'b0,
    star_first: 1'b0,
    star_last:  1'b0
  };

  function automatic logic [FLAGS_W-1:0] flag_bit(input logic [7:0] ch);
    logic [FLAGS_W-1:0] f;
    f = '0;
    case (ch)
      CH_SHARP: f[FL_SHARP] = 1'b1;
      CH_ZERO:  f[FL_ZERO]  = 1'b1;
      CH_PLUS:  f[FL_PLUS]  = 1'b1;
      CH_MINUS: f[FL_MINUS] = 1'b1;
      CH_SPACE: f[FL_SPACE] = 1'b1;
      default:  f = '0;
    endcase
    return f;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return (ch >= CH_ZERO) && (ch <= CH_NINE);
  endfunction

endpackage

// ----- rtl/fsop_sat_acc.sv -----
// saturating decimal accumulate: acc * 10 + digit, clamped to all ones
module fsop_sat_acc #(
  parameter int VALUE_BITS = 16
) (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [3:0]            digit,
  output logic [VALUE_BITS-1:0] result
);

  logic [VALUE_BITS+3:0] sum;

  always_comb begin
    // times ten as shift and add
    sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_BITS{1'b0}}, digit};
    if (sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
      result = {VALUE_BITS{1'b1}};
    end else begin
      result = sum[VALUE_BITS-1:0];
    end
  end

endmodule

// ----- rtl/fsop_step.sv -----
// one character of parsing: phase skip, field update and result assembly
module fsop_step #(
  parameter int VALUE_BITS = 16
) (
  input  fsop_pkg::ctl_t                    cur_ctl,
  input  logic [VALUE_BITS-1:0]             cur_width,
  input  logic [VALUE_BITS-1:0]             cur_prec,
  input  logic [7:0]                        ch,
  input  logic                              start,
  output fsop_pkg::ctl_t                    nxt_ctl,
  output logic [VALUE_BITS-1:0]             nxt_width,
  output logic [VALUE_BITS-1:0]             nxt_prec,
  output logic                              res_valid,
  output logic [fsop_pkg::OUT_TDATA_W-1:0]  res_data
);

  fsop_pkg::ctl_t        base;
  logic [VALUE_BITS-1:0] base_width;
  logic [VALUE_BITS-1:0] base_prec;
  logic [VALUE_BITS-1:0] width_sat;
  logic [VALUE_BITS-1:0] prec_sat;
  logic [fsop_pkg::NUM_PHASES-1:0] match;
  logic [3:0]            p;
  logic [3:0]            q;
  logic [fsop_pkg::FLAGS_W-1:0] fl;
  logic [VALUE_BITS+15:0] width_ext;
  logic [VALUE_BITS+15:0] prec_ext;
  fsop_pkg::ctl_t        upd;

  always_comb begin
    if (start) begin
      base       = fsop_pkg::CTL_RESET;
      base_width = '0;
      base_prec  = {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end else begin
      base       = cur_ctl;
      base_width = cur_width;
      base_prec  = cur_prec;
    end
  end

  fsop_sat_acc #(.VALUE_BITS(VALUE_BITS)) u_width_acc (
    .acc    (base_width),
    .digit  (ch[3:0]),
    .result (width_sat)
  );

  fsop_sat_acc #(.VALUE_BITS(VALUE_BITS)) u_prec_acc (
    .acc    (base_prec),
    .digit  (ch[3:0]),
    .result (prec_sat)
  );

  // which phases would consume this character
  always_comb begin
    match = '0;
    match[fsop_pkg::PH_STAR1]   = (ch == fsop_pkg::CH_STAR);
    match[fsop_pkg::PH_FLAGS1]  = (fsop_pkg::flag_bit(ch) != '0);
    match[fsop_pkg::PH_WSTART]  = (ch >= fsop_pkg::CH_ONE) && (ch <= fsop_pkg::CH_NINE);
    // a digit run only goes on from its own phase; its start phase skips past it
    match[fsop_pkg::PH_WDIGITS] = fsop_pkg::is_digit(ch) &&
                                  (base.phase == fsop_pkg::PH_WDIGITS);
    match[fsop_pkg::PH_PSTART]  = (ch == fsop_pkg::CH_DOT);
    match[fsop_pkg::PH_PDIGITS] = fsop_pkg::is_digit(ch) &&
                                  (base.phase == fsop_pkg::PH_PDIGITS);
    match[fsop_pkg::PH_LEN]     = (ch == fsop_pkg::CH_LOW_H) || (ch == fsop_pkg::CH_LOW_L) ||
                                  (ch == fsop_pkg::CH_UP_L) || (ch == fsop_pkg::CH_LOW_J) ||
                                  (ch == fsop_pkg::CH_LOW_Z);
    match[fsop_pkg::PH_FLAGS2]  = match[fsop_pkg::PH_FLAGS1];
    match[fsop_pkg::PH_STAR2]   = match[fsop_pkg::PH_STAR1];
    match[fsop_pkg::PH_STOP]    = 1'b1;
  end

  // first consuming phase at or after the current one; stop always consumes
  always_comb begin
    p = base.phase;
    q = fsop_pkg::PH_STOP;
    for (int i = fsop_pkg::NUM_PHASES - 1; i >= 0; i--) begin
      if ((4'(i) >= p) && match[i]) begin
        q = 4'(i);
      end
    end
  end

  always_comb begin
    upd       = base;
    nxt_width = base_width;
    nxt_prec  = base_prec;
    fl        = base.flags;
    // leaving a flag group without consuming applies cancellation
    if (((p <= fsop_pkg::PH_FLAGS1) && (q > fsop_pkg::PH_FLAGS1)) ||
        ((p <= fsop_pkg::PH_FLAGS2) && (q > fsop_pkg::PH_FLAGS2))) begin
      if (fl[fsop_pkg::FL_MINUS]) begin
        fl[fsop_pkg::FL_ZERO] = 1'b0;
      end
      if (fl[fsop_pkg::FL_PLUS]) begin
        fl[fsop_pkg::FL_SPACE] = 1'b0;
      end
    end
    upd.flags = fl;
    if ((p <= fsop_pkg::PH_LEN) && (q > fsop_pkg::PH_LEN)) begin
      upd.pend_h = 1'b0;
      upd.pend_l = 1'b0;
    end
    upd.phase = fsop_pkg::phase_t'(q);
    unique case (fsop_pkg::phase_t'(q))
      fsop_pkg::PH_STAR1: begin
        upd.star_first = 1'b1;
        upd.phase      = fsop_pkg::PH_FLAGS1;
      end
      fsop_pkg::PH_FLAGS1, fsop_pkg::PH_FLAGS2: begin
        upd.flags = fl | fsop_pkg::flag_bit(ch);
      end
      fsop_pkg::PH_WSTART: begin
        nxt_width = {{(VALUE_BITS-4){1'b0}}, ch[3:0]};
        upd.phase = fsop_pkg::PH_WDIGITS;
      end
      fsop_pkg::PH_WDIGITS: begin
        nxt_width = width_sat;
      end
      fsop_pkg::PH_PSTART: begin
        upd.prec_seen = 1'b1;
        nxt_prec      = '0;
        upd.phase     = fsop_pkg::PH_PDIGITS;
      end
      fsop_pkg::PH_PDIGITS: begin
        nxt_prec = prec_sat;
      end
      fsop_pkg::PH_LEN: begin
        case (ch)
          fsop_pkg::CH_LOW_H: begin
            upd.pend_l = 1'b0;
            if (base.pend_h) begin
              upd.short_lvl = fsop_pkg::LVL_DOUBLE;
              upd.pend_h    = 1'b0;
            end else begin
              upd.short_lvl = fsop_pkg::LVL_SINGLE;
              upd.pend_h    = 1'b1;
            end
          end
          fsop_pkg::CH_LOW_L: begin
            upd.pend_h = 1'b0;
            if (base.pend_l) begin
              upd.long_lvl = fsop_pkg::LVL_DOUBLE;
              upd.pend_l   = 1'b0;
            end else begin
              upd.long_lvl = fsop_pkg::LVL_SINGLE;
              upd.pend_l   = 1'b1;
            end
          end
          fsop_pkg::CH_UP_L: begin
            upd.pend_h   = 1'b0;
            upd.pend_l   = 1'b0;
            upd.long_lvl = fsop_pkg::LVL_DOUBLE;
          end
          fsop_pkg::CH_LOW_J: begin
            upd.pend_h = 1'b0;
            upd.pend_l = 1'b0;
            upd.intmax = 1'b1;
          end
          default: begin
            upd.pend_h = 1'b0;
            upd.pend_l = 1'b0;
            upd.sizet  = 1'b1;
          end
        endcase
      end
      fsop_pkg::PH_STAR2: begin
        upd.star_last = 1'b1;
        upd.phase     = fsop_pkg::PH_STOP;
      end
      default: begin
        upd.phase = fsop_pkg::PH_STOP;
      end
    endcase
  end

  assign res_valid = (q == fsop_pkg::PH_STOP);

  // field values are cut or zero extended to the 16 bit result fields
  assign width_ext = {16'd0, base_width};
  assign prec_ext  = {16'd0, base_prec};

  always_comb begin
    res_data = '0;
    res_data[fsop_pkg::OUT_BITS-1:0] = {
      upd.star_last, upd.star_first, upd.sizet, upd.intmax,
      upd.long_lvl, upd.short_lvl, upd.prec_seen,
      prec_ext[15:0], width_ext[15:0], upd.flags, ch
    };
  end

  always_comb begin
    if (res_valid) begin
      nxt_ctl = fsop_pkg::CTL_RESET;
    end else begin
      nxt_ctl = upd;
    end
  end

endmodule

// ----- rtl/format_spec_option_parser.sv -----
// top level of the format specifier option parser: input, state and result registers
//
// Usage: send the characters that follow a percent sign on the in_ stream, one
// transfer each. in_tdata carries the character, in_tuser marks the first
// character of a specifier and clears the parse state before it is handled.
// Characters that are consumed give no output; the first character that is not
// consumed (the conversion letter, a NUL or anything unexpected) gives one
// transfer on the out_ stream with all parsed fields, and the parser returns
// to its initial state so the next character starts a new specifier.
// A result passes through the input register, then the parse logic into the
// result register.
// Throughput: one character per cycle while no result waits for a full output
// register, set by the single parse step between the input register and the
// state and result registers.
// Reset (rst_n low, synchronous) empties both registers and returns the parse
// state to its initial values. When the receiver holds out_tready low the
// result stays in the output register; characters that produce no result keep
// flowing, and one that would produce a result waits in the input register,
// after which in_tready drops until the output register frees.
module format_spec_option_parser #(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] start_req
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] stop_char, [12:8] flag_bits, [28:13] min_width,
  // [44:29] precision_value, [45] precision_given, [47:46] short_level,
  // [49:48] long_level, [50] intmax_mod, [51] sizet_mod, [52] star_before,
  // [53] star_after, [55:54] zero
  output logic [fsop_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                  in_valid_r;
  logic [7:0]            in_ch_r;
  logic                  in_start_r;
  fsop_pkg::ctl_t        ctl_r;
  fsop_pkg::ctl_t        ctl_nxt;
  logic [VALUE_BITS-1:0] width_r;
  logic [VALUE_BITS-1:0] width_nxt;
  logic [VALUE_BITS-1:0] prec_r;
  logic [VALUE_BITS-1:0] prec_nxt;
  logic                  out_valid_r;
  logic [fsop_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic [fsop_pkg::OUT_TDATA_W-1:0] res_data;
  logic                  res_valid;
  logic                  out_free;
  logic                  advance;
  logic [VALUE_BITS-1:0] width_fin;
  logic [VALUE_BITS-1:0] prec_fin;

  fsop_step #(.VALUE_BITS(VALUE_BITS)) u_step (
    .cur_ctl   (ctl_r),
    .cur_width (width_r),
    .cur_prec  (prec_r),
    .ch        (in_ch_r),
    .start     (in_start_r),
    .nxt_ctl   (ctl_nxt),
    .nxt_width (width_nxt),
    .nxt_prec  (prec_nxt),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && (out_free || !res_valid);
  assign in_tready = !in_valid_r || advance;

  // a finished specifier restarts the accumulators from their initial values
  assign width_fin = res_valid ? '0 : width_nxt;
  assign prec_fin  = res_valid ? {{(VALUE_BITS-1){1'b0}}, 1'b1} : prec_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_ch_r    <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= fsop_pkg::CTL_RESET;
      width_r <= '0;
      prec_r  <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
    end else if (advance) begin
      ctl_r   <= ctl_nxt;
      width_r <= width_fin;
      prec_r  <= prec_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- dv/fsop_checker.sv -----
// transfer monitor, specifier predictor and result comparison for the format specifier parser
module fsop_checker
  import fsop_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int unsigned            fail_count,
  output int unsigned            results_owed
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_BITS) - 64'd1;

  // lowest field last, so the struct lines up with out_tdata from bit 0
  typedef struct packed {
    logic               star_after;
    logic               star_before;
    logic               sizet;
    logic               intmax;
    logic [LVL_W-1:0]   long_lvl;
    logic [LVL_W-1:0]   short_lvl;
    logic               prec_given;
    logic [FIELD_W-1:0] prec;
    logic [FIELD_W-1:0] width;
    logic [FLAGS_W-1:0] flags;
    logic [CH_W-1:0]    stop;
  } spec_t;

  phase_t             p_phase;
  logic [FLAGS_W-1:0] p_flags;
  longint unsigned    p_width;
  longint unsigned    p_prec;
  logic               p_prec_seen;
  logic [LVL_W-1:0]   p_short;
  logic [LVL_W-1:0]   p_long;
  logic               p_intmax;
  logic               p_sizet;
  logic               p_h_pending;
  logic               p_l_pending;
  logic               p_star_lead;
  logic               p_star_trail;

  spec_t pending_specs[$];
  spec_t predicted;
  spec_t got;
  spec_t want;

  function automatic void clear_spec();
    p_phase      = PH_STAR1;
    p_flags      = '0;
    p_width      = 0;
    p_prec       = 1;
    p_prec_seen  = 1'b0;
    p_short      = LVL_NONE;
    p_long       = LVL_NONE;
    p_intmax     = 1'b0;
    p_sizet      = 1'b0;
    p_h_pending  = 1'b0;
    p_l_pending  = 1'b0;
    p_star_lead  = 1'b0;
    p_star_trail = 1'b0;
  endfunction

  function automatic logic [FLAGS_W-1:0] flag_of(input logic [7:0] c);
    logic [FLAGS_W-1:0] m;
    m = '0;
    if (c == CH_SHARP) m[FL_SHARP] = 1'b1;
    if (c == CH_ZERO)  m[FL_ZERO]  = 1'b1;
    if (c == CH_PLUS)  m[FL_PLUS]  = 1'b1;
    if (c == CH_MINUS) m[FL_MINUS] = 1'b1;
    if (c == CH_SPACE) m[FL_SPACE] = 1'b1;
    return m;
  endfunction

  function automatic longint unsigned times_ten_plus(input longint unsigned acc,
                                                     input logic [7:0] c);
    longint unsigned v;
    v = acc * 10 + (c - CH_ZERO);
    return (v > VALUE_MAX) ? VALUE_MAX : v;
  endfunction

  // one character through the parse; returns 1 when it ends the specifier
  function automatic bit parse_char(input logic [7:0] c, input logic start,
                                    output spec_t res);
    logic [FLAGS_W-1:0] fb;
    logic               digit;
    res   = '0;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    if (start) clear_spec();
    while (1'b1) begin
      case (p_phase)
        PH_STAR1: begin
          p_phase = PH_FLAGS1;
          if (c == CH_STAR) begin
            p_star_lead = 1'b1;
            return 1'b0;
          end
        end
        PH_FLAGS1, PH_FLAGS2: begin
          fb = flag_of(c);
          if (fb != '0) begin
            p_flags |= fb;
            return 1'b0;
          end
          // minus beats zero, plus beats space
          if (p_flags[FL_MINUS]) p_flags[FL_ZERO] = 1'b0;
          if (p_flags[FL_PLUS]) p_flags[FL_SPACE] = 1'b0;
          p_phase = (p_phase == PH_FLAGS1) ? PH_WSTART : PH_STAR2;
        end
        PH_WSTART: begin
          if (c >= CH_ONE && c <= CH_NINE) begin
            p_width = c - CH_ZERO;
            p_phase = PH_WDIGITS;
            return 1'b0;
          end
          p_phase = PH_PSTART;
        end
        PH_WDIGITS: begin
          if (digit) begin
            p_width = times_ten_plus(p_width, c);
            return 1'b0;
          end
          p_phase = PH_PSTART;
        end
        PH_PSTART: begin
          if (c == CH_DOT) begin
            p_prec_seen = 1'b1;
            p_prec      = 0;
            p_phase     = PH_PDIGITS;
            return 1'b0;
          end
          p_phase = PH_LEN;
        end
        PH_PDIGITS: begin
          if (digit) begin
            p_prec = times_ten_plus(p_prec, c);
            return 1'b0;
          end
          p_phase = PH_LEN;
        end
        PH_LEN: begin
          if (c == CH_LOW_H) begin
            p_l_pending = 1'b0;
            p_short     = p_h_pending ? LVL_DOUBLE : LVL_SINGLE;
            p_h_pending = !p_h_pending;
            return 1'b0;
          end
          if (c == CH_LOW_L) begin
            p_h_pending = 1'b0;
            p_long      = p_l_pending ? LVL_DOUBLE : LVL_SINGLE;
            p_l_pending = !p_l_pending;
            return 1'b0;
          end
          p_h_pending = 1'b0;
          p_l_pending = 1'b0;
          if (c == CH_UP_L) begin
            p_long = LVL_DOUBLE;
            return 1'b0;
          end
          if (c == CH_LOW_J) begin
            p_intmax = 1'b1;
            return 1'b0;
          end
          if (c == CH_LOW_Z) begin
            p_sizet = 1'b1;
            return 1'b0;
          end
          p_phase = PH_FLAGS2;
        end
        PH_STAR2: begin
          p_phase = PH_STOP;
          if (c == CH_STAR) begin
            p_star_trail = 1'b1;
            return 1'b0;
          end
        end
        default: begin
          res.stop        = c;
          res.flags       = p_flags;
          res.width       = p_width[FIELD_W-1:0];
          res.prec        = p_prec[FIELD_W-1:0];
          res.prec_given  = p_prec_seen;
          res.short_lvl   = p_short;
          res.long_lvl    = p_long;
          res.intmax      = p_intmax;
          res.sizet       = p_sizet;
          res.star_before = p_star_lead;
          res.star_after  = p_star_trail;
          clear_spec();
          return 1'b1;
        end
      endcase
    end
    return 1'b0;
  endfunction

  function automatic string spec_text(input spec_t s);
    return $sformatf({"stop=%02h flags=%02h width=%0d prec=%0d dot=%0b h=%0d l=%0d",
                      " j=%0b z=%0b star=%0b/%0b"},
                     s.stop, s.flags, s.width, s.prec, s.prec_given, s.short_lvl,
                     s.long_lvl, s.intmax, s.sizet, s.star_before, s.star_after);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_spec();
    end else begin
      if (in_tvalid && in_tready) begin
        if (parse_char(in_tdata, in_tuser, predicted)) pending_specs.push_back(predicted);
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[OUT_BITS-1:0];
        if (pending_specs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transfer: %s", spec_text(got));
        end else begin
          want = pending_specs.pop_front();
          if (got.stop != want.stop || got.flags != want.flags ||
              got.width != want.width || got.prec != want.prec ||
              got.prec_given != want.prec_given || got.short_lvl != want.short_lvl ||
              got.long_lvl != want.long_lvl || got.intmax != want.intmax ||
              got.sizet != want.sizet || got.star_before != want.star_before ||
              got.star_after != want.star_after) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result mismatch at %0t\n  expected %s\n  actual   %s",
                       $realtime, spec_text(want), spec_text(got));
            end
          end
        end
      end
    end
    results_owed = pending_specs.size();
  end

endmodule

// ----- dv/tb_format_spec_option_parser.sv -----
// stimulus, flow control and verdict for the format specifier option parser
module tb_format_spec_option_parser;

  timeunit 1ns;
  timeprecision 1ps;

  import fsop_pkg::*;

  localparam int         VALUE_BITS     = 16;
  localparam int         ITEM_TARGET    = 1050;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam logic [7:0] CH_NUL         = 8'h00;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int unsigned fail_count;
  int unsigned results_owed;

  int    items_sent    = 0;
  int    rx_stall_left = 0;
  int    quiet         = 0;
  bit    tx_idle       = 1'b1;
  bit    rx_idle       = 1'b1;
  bit    hold_req      = 1'b0;
  bit    need_start    = 1'b1;
  string conv_letters  = "diouxXcspfegn%";

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  format_spec_option_parser #(.VALUE_BITS(VALUE_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fsop_checker #(.VALUE_BITS(VALUE_BITS)) u_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(0, 4))
      0:       return CH_SHARP;
      1:       return CH_ZERO;
      2:       return CH_PLUS;
      3:       return CH_MINUS;
      default: return CH_SPACE;
    endcase
  endfunction

  // h and l weighted up so doubled and tripled runs turn up
  function automatic logic [7:0] pick_modifier();
    case ($urandom_range(0, 6))
      0, 1:    return CH_LOW_H;
      2, 3:    return CH_LOW_L;
      4:       return CH_UP_L;
      5:       return CH_LOW_J;
      default: return CH_LOW_Z;
    endcase
  endfunction

  // digit count, occasionally long enough to saturate
  function automatic int digit_count();
    return ($urandom_range(0, 14) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 2);
  endfunction

  // every call starts and ends at a falling edge
  task automatic send_char(input logic [7:0] c, input logic start);
    int gap;
    gap = (tx_idle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    wait (results_owed == 0);
    @(negedge clk);
  endtask

  // well-formed specifier with random content; broken ones are cut short
  task automatic send_spec(input bit broken);
    logic [7:0] seq[$];
    int         keep;
    int         r;
    bit         start;
    if ($urandom_range(0, 4) == 0) seq.push_back(CH_STAR);
    repeat ($urandom_range(0, 3)) seq.push_back(pick_flag());
    if ($urandom_range(0, 1) == 1) begin
      seq.push_back(8'(CH_ONE + $urandom_range(0, 8)));
      repeat (digit_count()) seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 2) == 0) begin
      seq.push_back(CH_DOT);
      repeat (digit_count()) seq.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    repeat ($urandom_range(0, 3)) seq.push_back(pick_modifier());
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) seq.push_back(pick_flag());
    if ($urandom_range(0, 5) == 0) seq.push_back(CH_STAR);
    r = $urandom_range(0, 9);
    if (r < 7) seq.push_back(conv_letters[$urandom_range(0, conv_letters.len() - 1)]);
    else if (r == 7) seq.push_back(CH_NUL);
    else seq.push_back(8'($urandom_range(0, 255)));
    if (broken) begin
      keep = $urandom_range(0, seq.size() - 1);
      while (seq.size() > keep) void'(seq.pop_back());
    end
    start = need_start || ($urandom_range(0, 3) != 0);
    for (int i = 0; i < seq.size(); i++) send_char(seq[i], start && i == 0);
    need_start = broken;
  endtask

  // receiver: random stalls, stretches without, and one long hold on request
  initial begin : rx_side
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (rx_stall_left > 0) begin
        out_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_idle && $urandom_range(0, 4) == 0) rx_stall_left = gap_len();
      end
    end
  end

  initial begin : watchdog
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("tb_format_spec_option_parser failed");
    $finish;
  end

  initial begin : stimulus
    bit held;
    bit paused;
    int r;
    held   = 1'b0;
    paused = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // NUL straight away, then every flag with both cancellations, a saturating
    // width and a leading star
    send_char(CH_NUL, 1'b1);
    send_text("*-0+ #70000d");
    // bare dot, l then L, j, z, a second flag group, trailing star, NUL stop
    send_text(".lLjz-*");
    send_char(CH_NUL, 1'b0);
    // third h falls back to a single one
    send_text("hhhu");
    wait_for_results();

    while (items_sent < ITEM_TARGET) begin
      if (!held && items_sent >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (!paused && items_sent >= 500) begin
        wait_for_results();
        paused  = 1'b1;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (paused && !tx_idle && items_sent >= 700) begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        need_start = 1'b1;
      end else begin
        send_spec(r == 1);
      end
    end

    in_tvalid <= 1'b0;
    wait (results_owed == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb_format_spec_option_parser passed");
    else $display("tb_format_spec_option_parser failed");
    $finish;
  end

endmodule
